// ===== hdl/acsb_pkg.sv =====
// Package for the antialiased circle stamp blender: shared types and constants.
// No dependencies; imported by acsb_sqrt, acsb_div and the top level.
`default_nettype none
package acsb_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 2;
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_RADIUS,
    REG_COLOR
  } cfg_reg_e;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned CH_W       = 8;

  // Coverage in 1/256 pixel; an edge of 1.5 pixels or more gives full coverage.
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned COV_W       = 9;
  localparam int unsigned COV_ONE     = 256;
  localparam int unsigned EDGE_SAT    = 384;
  localparam int unsigned X2_W        = 10;
  localparam int unsigned RECIP3      = 683;
  localparam int unsigned RECIP3_SH   = 11;
  localparam int unsigned RECIP255    = 32897;
  localparam int unsigned RECIP255_SH = 23;

  // Colour divider: three channel lanes, eight quotient bits.
  localparam int unsigned LANES = 3;
  localparam int unsigned QB    = 8;
  localparam int unsigned NUM_W = 24;
  localparam int unsigned DEN_W = 16;

  typedef struct packed {
    logic             in_circle;
    logic [PIX_W-1:0] dest;
  } sq_side_t;

  typedef struct packed {
    logic             wr;
    logic             full;
    logic [CH_W-1:0]  sa;
    logic [CH_W-1:0]  oa;
    logic [PIX_W-1:0] dest;
  } dv_side_t;

endpackage
`default_nettype wire

// ===== hdl/antialiased_circle_stamp_blend.sv =====
// Antialiased circle stamp with source-over blend. Depends on acsb_pkg,
// acsb_sqrt and acsb_div.
// Throughput: one item per clock; the depth is set by the square root, which
// resolves one root bit per stage, and the colour divider, one bit per stage.
// The receiver cannot stall, so busy stays low. Reset clears all valid bits
// and the configuration registers; the pipeline never holds an item back.
`default_nettype none
module antialiased_circle_stamp_blend #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [COORD_BITS-1:0]           pixel_x_i,
  input  logic [COORD_BITS-1:0]           pixel_y_i,
  input  logic [acsb_pkg::PIX_W-1:0]      dest_pixel_i,
  input  logic                            cfg_we_i,
  input  logic [acsb_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [acsb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                            result_valid_o,
  output logic [acsb_pkg::PIX_W-1:0]      result_pixel_o,
  output logic                            write_enable_o
);
  import acsb_pkg::*;

  localparam int unsigned CW  = COORD_BITS + 2;
  localparam int unsigned AW  = COORD_BITS + 2;
  localparam int unsigned DXW = COORD_BITS + 3;
  localparam int unsigned SQW = 2 * AW;
  localparam int unsigned D2W = SQW + 1;
  localparam int unsigned RRW = 2 * COORD_BITS;
  localparam int unsigned RB  = COORD_BITS + FRAC_W;
  localparam int unsigned NW  = 2 * RB;
  localparam int unsigned LAT = RB + QB + 10;

  // Configuration registers.
  logic [CW-1:0]         center_x_q, center_y_q;
  logic [COORD_BITS-1:0] radius_q;
  logic [PIX_W-1:0]      color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= '0;
      color_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_CENTER_X: center_x_q <= cfg_wdata_i[CW-1:0];
        REG_CENTER_Y: center_y_q <= cfg_wdata_i[CW-1:0];
        REG_RADIUS:   radius_q   <= cfg_wdata_i[COORD_BITS-1:0];
        REG_COLOR:    color_q    <= cfg_wdata_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: absolute offsets from the centre.
  logic [DXW-1:0] dx, dy, ndx, ndy;
  assign dx  = {3'b000, pixel_x_i} - {center_x_q[CW-1], center_x_q};
  assign dy  = {3'b000, pixel_y_i} - {center_y_q[CW-1], center_y_q};
  assign ndx = DXW'(0) - dx;
  assign ndy = DXW'(0) - dy;

  logic             v1_q;
  logic [AW-1:0]    adx1_q, ady1_q;
  logic [PIX_W-1:0] dest1_q;

  // Stage 2: squares.
  logic             v2_q;
  logic [SQW-1:0]   sqx2_q, sqy2_q;
  logic [RRW-1:0]   rr2_q;
  logic [PIX_W-1:0] dest2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    adx1_q  <= dx[DXW-1] ? ndx[AW-1:0] : dx[AW-1:0];
    ady1_q  <= dy[DXW-1] ? ndy[AW-1:0] : dy[AW-1:0];
    dest1_q <= dest_pixel_i;
    sqx2_q  <= adx1_q * adx1_q;
    sqy2_q  <= ady1_q * ady1_q;
    rr2_q   <= radius_q * radius_q;
    dest2_q <= dest1_q;
  end

  // Stage 3: inside test; the square root's input register follows.
  logic [D2W-1:0] d2;
  logic [NW-1:0]  radicand;
  sq_side_t       sq_in, sq_out;
  logic           sq_valid;
  logic [RB-1:0]  root;

  assign d2       = {1'b0, sqx2_q} + {1'b0, sqy2_q};
  assign radicand = {d2[RRW-1:0], 16'h0000};
  assign sq_in.in_circle = (radius_q != '0) && (d2 <= D2W'(rr2_q));
  assign sq_in.dest      = dest2_q;

  acsb_sqrt #(
    .RB (RB)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v2_q),
    .radicand_i (radicand),
    .side_i     (sq_in),
    .valid_o    (sq_valid),
    .root_o     (root),
    .side_o     (sq_out)
  );

  // Stage 4: edge distance and saturation test.
  logic [RB-1:0] edge_dist;
  assign edge_dist = {radius_q, 8'h00} - root;

  logic            v4_q, v5_q, v6_q, v7_q, v8_q;
  logic            big4_q;
  logic [X2_W-1:0] x24_q;
  sq_side_t        side4_q, side5_q, side6_q;

  // Stage 5: coverage by a reciprocal multiply for the division by three.
  logic [2*X2_W-1:0] prod3;
  logic [COV_W-1:0]  cov5_q;
  assign prod3 = x24_q * X2_W'(RECIP3);

  // Stage 6: stamp alpha.
  logic [2*CH_W:0] ap;
  logic [CH_W-1:0] sa6_q;
  assign ap = color_q[31:24] * cov5_q;

  // Stage 7: alpha terms.
  logic [DEN_W-1:0] sa255_7_q, dainv7_q;
  logic [CH_W-1:0]  sa7_q;
  logic             wr7_q, full7_q;
  logic [PIX_W-1:0] dest7_q;
  logic [CH_W-1:0]  inv6;
  assign inv6 = 8'hFF - sa6_q;

  // Stage 8: channel products and the output alpha numerator.
  logic [LANES-1:0][NUM_W-1:0] ps8_q, pd8_q;
  logic [DEN_W-1:0]            a8_q;
  logic [CH_W-1:0]             sa8_q;
  logic                        wr8_q, full8_q;
  logic [PIX_W-1:0]            dest8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      v4_q <= sq_valid;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    big4_q    <= edge_dist >= RB'(EDGE_SAT);
    x24_q     <= {edge_dist[X2_W-2:0], 1'b0};
    side4_q   <= sq_out;
    cov5_q    <= big4_q ? COV_W'(COV_ONE) : prod3[RECIP3_SH+COV_W-1:RECIP3_SH];
    side5_q   <= side4_q;
    sa6_q     <= ap[2*CH_W-1:CH_W];
    side6_q   <= side5_q;
    sa255_7_q <= {sa6_q, 8'h00} - {8'h00, sa6_q};
    dainv7_q  <= side6_q.dest[31:24] * inv6;
    sa7_q     <= sa6_q;
    wr7_q     <= side6_q.in_circle && (sa6_q != '0);
    full7_q   <= sa6_q == 8'hFF;
    dest7_q   <= side6_q.dest;
    a8_q      <= sa255_7_q + dainv7_q;
    sa8_q     <= sa7_q;
    wr8_q     <= wr7_q;
    full8_q   <= full7_q;
    dest8_q   <= dest7_q;
  end

  for (genvar c = 0; c < LANES; c++) begin : g_chan
    always_ff @(posedge clk_i) begin
      ps8_q[c] <= color_q[CH_W*c +: CH_W] * sa255_7_q;
      pd8_q[c] <= dest7_q[CH_W*c +: CH_W] * dainv7_q;
    end
  end

  // Stage 9: numerators and output alpha, into the divider.
  logic [LANES-1:0][NUM_W-1:0] num;
  logic [2*DEN_W-1:0]          prod255;
  dv_side_t                    dv_in, dv_out;
  logic                        dv_valid;
  logic [LANES-1:0][QB-1:0]    quot;

  for (genvar c = 0; c < LANES; c++) begin : g_num
    assign num[c] = ps8_q[c] + pd8_q[c];
  end

  assign prod255    = a8_q * DEN_W'(RECIP255);
  assign dv_in.wr   = wr8_q;
  assign dv_in.full = full8_q;
  assign dv_in.sa   = sa8_q;
  assign dv_in.oa   = prod255[RECIP255_SH+CH_W-1:RECIP255_SH];
  assign dv_in.dest = dest8_q;

  acsb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .num_i   (num),
    .den_i   (a8_q),
    .side_i  (dv_in),
    .valid_o (dv_valid),
    .quot_o  (quot),
    .side_o  (dv_out)
  );

  // Output register: untouched pixel, opaque stamp, or blended value.
  logic             out_valid_q, out_we_q;
  logic [PIX_W-1:0] out_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_we_q <= dv_out.wr;
    if (!dv_out.wr) begin
      out_pix_q <= dv_out.dest;
    end else if (dv_out.full) begin
      out_pix_q <= {dv_out.sa, color_q[23:0]};
    end else begin
      out_pix_q <= {dv_out.oa, quot[2], quot[1], quot[0]};
    end
  end

  assign result_valid_o = out_valid_q;
  assign write_enable_o = out_valid_q && out_we_q;
  assign result_pixel_o = out_pix_q;

  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LAT result_valid_o)
    else $error("item did not reach the output after the pipeline depth");

  a_lat_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, LAT))
    else $error("result without a matching item");

  a_we_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_enable_o |-> (radius_q != '0))
    else $error("write with zero radius");

  a_sq_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid |-> ##5 dv_in.wr == 1'b0 || v8_q)
    else $error("divider input written without a valid item");

endmodule
`default_nettype wire

// ===== hdl/acsb_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Depends on acsb_pkg for the side data that travels with each item.
`default_nettype none
module acsb_sqrt #(
  parameter int unsigned RB = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [2*RB-1:0]      radicand_i,
  input  acsb_pkg::sq_side_t   side_i,
  output logic                 valid_o,
  output logic [RB-1:0]        root_o,
  output acsb_pkg::sq_side_t   side_o
);
  import acsb_pkg::*;

  localparam int unsigned NW = 2 * RB;

  logic          vld_q  [0:RB];
  logic [NW-1:0] rem_q  [0:RB];
  logic [RB-1:0] root_q [0:RB];
  sq_side_t      side_q [0:RB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= radicand_i;
    root_q[0] <= '0;
    side_q[0] <= side_i;
  end

  for (genvar k = 0; k < RB; k++) begin : g_stage
    localparam int unsigned BI = RB - 1 - k;
    logic [NW:0] trial;
    logic        take;

    // The root found so far has no bits at or below BI, so the trial term
    // 2*Q*2^BI + 4^BI is formed by an OR.
    assign trial = ((NW+1)'(root_q[k]) << (BI + 1)) | ((NW+1)'(1) << (2 * BI));
    assign take  = {1'b0, rem_q[k]} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= take ? NW'({1'b0, rem_q[k]} - trial) : rem_q[k];
      root_q[k+1] <= take ? (root_q[k] | (RB'(1) << BI)) : root_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = vld_q[RB];
  assign root_o  = root_q[RB];
  assign side_o  = side_q[RB];

endmodule
`default_nettype wire

// ===== hdl/acsb_div.sv =====
// Pipelined restoring divider for the three colour channels, one quotient
// bit per stage. Depends on acsb_pkg for widths and side data.
`default_nettype none
module acsb_div (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         valid_i,
  input  logic [acsb_pkg::LANES-1:0][acsb_pkg::NUM_W-1:0] num_i,
  input  logic [acsb_pkg::DEN_W-1:0]                   den_i,
  input  acsb_pkg::dv_side_t                           side_i,
  output logic                                         valid_o,
  output logic [acsb_pkg::LANES-1:0][acsb_pkg::QB-1:0] quot_o,
  output acsb_pkg::dv_side_t                           side_o
);
  import acsb_pkg::*;

  // The numerator never exceeds 255 times the denominator, so eight
  // quotient bits cover every item.
  logic                              vld_q  [0:QB];
  logic [LANES-1:0][NUM_W-1:0]       rem_q  [0:QB];
  logic [LANES-1:0][QB-1:0]          quot_q [0:QB];
  logic [DEN_W-1:0]                  den_q  [0:QB];
  dv_side_t                          side_q [0:QB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_i;
    quot_q[0] <= '0;
    den_q[0]  <= den_i;
    side_q[0] <= side_i;
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int unsigned BI = QB - 1 - k;
    logic [NUM_W-1:0] trial;

    assign trial = NUM_W'(den_q[k]) << BI;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      always_ff @(posedge clk_i) begin
        if (rem_q[k][l] >= trial) begin
          rem_q[k+1][l]  <= rem_q[k][l] - trial;
          quot_q[k+1][l] <= quot_q[k][l] | (QB'(1) << BI);
        end else begin
          rem_q[k+1][l]  <= rem_q[k][l];
          quot_q[k+1][l] <= quot_q[k][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[k+1]  <= den_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = vld_q[QB];
  assign quot_o  = quot_q[QB];
  assign side_o  = side_q[QB];

endmodule
`default_nettype wire
